@@ rtl/core/prefix_polynomial_hash_core_macros.svh @@
// assertion macros shared by the prefix hash checker
// each macro expects clk and rst in the scope where it is used
`ifndef PREFIX_POLYNOMIAL_HASH_CORE_MACROS_SVH
`define PREFIX_POLYNOMIAL_HASH_CORE_MACROS_SVH

// same-cycle implication
`define PPH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/pph_pkg.sv @@
// types, constants and modular helpers for the prefix polynomial hash core
// no dependencies
`default_nettype none

package pph_pkg;

  localparam int DW = 30;

  typedef logic [DW-1:0] word_t;

  localparam word_t MOD_FIRST  = 30'd998244353;
  localparam word_t MOD_SECOND = 30'd1000000007;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] REG_BASE       = 2'd0;
  localparam logic [1:0] REG_INV_FIRST  = 2'd1;
  localparam logic [1:0] REG_INV_SECOND = 2'd2;

  typedef struct packed {
    logic  start;
    word_t a_first;
    word_t b_first;
    word_t a_second;
    word_t b_second;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t p_first;
    word_t p_second;
  } mm_rsp_t;

  // one conditional subtract, valid for x below 2m
  function automatic word_t red(input logic [DW:0] x, input word_t m);
    word_t r;
    if (x >= {1'b0, m}) r = DW'(x - {1'b0, m});
    else r = x[DW-1:0];
    return r;
  endfunction

  function automatic word_t add_mod(input word_t a, input word_t b, input word_t m);
    return red({1'b0, a} + {1'b0, b}, m);
  endfunction

  function automatic word_t sub_mod(input word_t a, input word_t b, input word_t m);
    word_t r;
    if (a >= b) r = a - b;
    else r = DW'({1'b0, a} + {1'b0, m} - {1'b0, b});
    return r;
  endfunction

  // one msb-first step of shift-and-add modular multiply
  function automatic word_t mm_step(input word_t acc, input word_t b, input logic bit_in,
                                    input word_t m);
    word_t t;
    t = red({acc, 1'b0}, m);
    return red({1'b0, t} + (bit_in ? {1'b0, b} : {(DW+1){1'b0}}), m);
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/pph_if.sv @@
// valid/ready channels of the prefix hash core: command in, result out
// depends on pph_pkg
`default_nettype none

interface pph_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  symbol;
  logic [11:0] range_start;
  logic [11:0] range_end;
  modport source (output valid, command, symbol, range_start, range_end, input ready);
  modport sink (input valid, command, symbol, range_start, range_end, output ready);
endinterface

interface pph_res_if;
  logic           valid;
  logic           ready;
  pph_pkg::word_t hash_first;
  pph_pkg::word_t hash_second;
  logic           status;
  modport source (output valid, hash_first, hash_second, status, input ready);
  modport sink (input valid, hash_first, hash_second, status, output ready);
endinterface

`default_nettype wire

@@ rtl/core/pph_modmul.sv @@
// bit-serial modular multiplier, one lane per modulus, one bit per cycle
// depends on pph_pkg
`default_nettype none

module pph_modmul (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pph_pkg::mm_req_t req,
  output pph_pkg::mm_rsp_t      rsp
);

  logic                 busy;
  logic                 done;
  logic [4:0]           cnt;
  pph_pkg::word_t       a_first, a_second;
  pph_pkg::word_t       b_first, b_second;
  pph_pkg::word_t       acc_first, acc_second;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy       <= 1'b1;
        cnt        <= 5'(pph_pkg::DW - 1);
        acc_first  <= '0;
        acc_second <= '0;
        a_first    <= req.a_first;
        a_second   <= req.a_second;
        // a needs no reduction, the running value stays below the modulus
        b_first    <= pph_pkg::red({1'b0, req.b_first}, pph_pkg::MOD_FIRST);
        b_second   <= pph_pkg::red({1'b0, req.b_second}, pph_pkg::MOD_SECOND);
      end else if (busy) begin
        acc_first  <= pph_pkg::mm_step(acc_first, b_first, a_first[cnt], pph_pkg::MOD_FIRST);
        acc_second <= pph_pkg::mm_step(acc_second, b_second, a_second[cnt],
                                       pph_pkg::MOD_SECOND);
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 5'd1;
        end
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.p_first  = acc_first;
  assign rsp.p_second = acc_second;

endmodule

`default_nettype wire

@@ rtl/core/prefix_polynomial_hash_core.sv @@
// Prefix polynomial hash core under the moduli 998244353 and 1000000007.
// Commands arrive on cmd (valid/ready): clear, append symbol, query range.
// Only a query produces a beat on res; clear, dropped appends and unused codes
// leave the core idle.
// Config is a plain write port (cfg_we, cfg_index, cfg_data): base, then the
// inverses of base under each modulus, supplied by software.
// One command is in work at a time; cmd.ready is high only when the core is idle.
// Append: two passes through the bit-serial multipliers (power update, then
// symbol times power), then one write to the prefix memory.
// Query: two prefix memory reads, one subtract and one multiply by the stored
// inverse power; cmd.ready returns in the same cycle that res.valid rises.
// A query that is empty or beyond the loaded length skips the multiply and
// gives status 1 with zero hashes.
// The result is held in an output register; a query that finishes while the
// previous result is unread waits until res.ready takes it.
// Reset empties the string and restores the register defaults; the memories are
// not cleared, only entries below the loaded length are ever used.
// depends on pph_pkg, pph_if, pph_modmul
`default_nettype none

module prefix_polynomial_hash_core #(
  parameter int MAX_LEN = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  pph_cmd_if.sink          cmd,
  pph_res_if.source        res,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [29:0] cfg_data
);

  localparam int AW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW  = $clog2(MAX_LEN + 1);
  localparam int CW  = (LW > 12) ? LW : 12;
  localparam int MW  = 2 * pph_pkg::DW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AP1  = 4'd1;
  localparam logic [3:0] S_AP2  = 4'd2;
  localparam logic [3:0] S_Q1   = 4'd3;
  localparam logic [3:0] S_Q2   = 4'd4;
  localparam logic [3:0] S_Q3   = 4'd5;
  localparam logic [3:0] S_FIN  = 4'd6;

  logic [3:0]     state;
  logic [LW-1:0]  len;
  logic [20:0]    base_r;
  pph_pkg::word_t ib_first, ib_second;
  pph_pkg::word_t pw_first, pw_second, ipw_first, ipw_second;
  pph_pkg::word_t last_first, last_second;
  pph_pkg::word_t hi_first, hi_second, il_first, il_second;
  pph_pkg::word_t d_first, d_second, lo_first, lo_second;
  pph_pkg::word_t sum_first, sum_second;
  pph_pkg::word_t fin_first, fin_second;
  pph_pkg::word_t out_first, out_second;
  logic           fin_status, out_status, out_valid, load_out;
  logic [7:0]     sym;
  logic [11:0]    l_q;

  logic [MW-1:0]  pre_mem [MAX_LEN];
  logic [MW-1:0]  inv_mem [MAX_LEN];
  logic [MW-1:0]  pre_rd, inv_rd;
  logic           pre_re, pre_we, inv_re, inv_we;
  logic [AW-1:0]  pre_ra, l_addr, len_addr;

  logic           accept, is_append, is_query, full, q_bad;
  logic [CW-1:0]  l_ext, r_ext, len_ext, lm1_ext, lq_ext;

  pph_pkg::mm_req_t req_a, req_b;
  pph_pkg::mm_rsp_t rsp_a, rsp_b;

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign is_append = accept && (cmd.command == pph_pkg::CMD_APPEND) && !full;
  assign is_query  = accept && (cmd.command == pph_pkg::CMD_QUERY);
  assign full      = (len == LW'(MAX_LEN));

  assign l_ext    = CW'(cmd.range_start);
  assign r_ext    = CW'(cmd.range_end);
  assign len_ext  = CW'(len);
  assign lq_ext   = CW'(l_q);
  assign lm1_ext  = lq_ext - CW'(1);
  assign q_bad    = (l_ext > r_ext) || (r_ext >= len_ext);
  assign l_addr   = l_ext[AW-1:0];
  assign len_addr = len[AW-1:0];

  // prefix memory: one read port, r first, then l-1
  always_comb begin
    pre_re = 1'b0;
    pre_ra = r_ext[AW-1:0];
    if (is_query && !q_bad) begin
      pre_re = 1'b1;
    end else if (state == S_Q1) begin
      pre_re = 1'b1;
      pre_ra = lm1_ext[AW-1:0];
    end
  end

  assign inv_re = is_query && !q_bad;
  assign inv_we = is_append;
  assign pre_we = (state == S_AP2) && rsp_a.done;

  always_ff @(posedge clk) begin
    if (pre_re) pre_rd <= pre_mem[pre_ra];
    if (pre_we) pre_mem[len_addr] <= {sum_first, sum_second};
  end

  always_ff @(posedge clk) begin
    if (inv_re) inv_rd <= inv_mem[l_addr];
    if (inv_we) inv_mem[len_addr] <= {ipw_first, ipw_second};
  end

  assign sum_first  = pph_pkg::add_mod(last_first, rsp_a.p_first, pph_pkg::MOD_FIRST);
  assign sum_second = pph_pkg::add_mod(last_second, rsp_a.p_second, pph_pkg::MOD_SECOND);

  assign lo_first  = (l_q == 12'd0) ? '0 : pre_rd[MW-1:pph_pkg::DW];
  assign lo_second = (l_q == 12'd0) ? '0 : pre_rd[pph_pkg::DW-1:0];
  assign d_first   = pph_pkg::sub_mod(hi_first, lo_first, pph_pkg::MOD_FIRST);
  assign d_second  = pph_pkg::sub_mod(hi_second, lo_second, pph_pkg::MOD_SECOND);

  // unit a: power times base, then symbol times new power
  always_comb begin
    req_a.start = is_append || ((state == S_AP1) && rsp_a.done);
    if (state == S_AP1) begin
      req_a.a_first  = pph_pkg::DW'(sym);
      req_a.b_first  = rsp_a.p_first;
      req_a.a_second = pph_pkg::DW'(sym);
      req_a.b_second = rsp_a.p_second;
    end else begin
      req_a.a_first  = pw_first;
      req_a.b_first  = pph_pkg::DW'(base_r);
      req_a.a_second = pw_second;
      req_a.b_second = pph_pkg::DW'(base_r);
    end
  end

  // unit b: inverse power update on append, final multiply on query
  always_comb begin
    req_b.start = is_append || (state == S_Q2);
    if (state == S_Q2) begin
      req_b.a_first  = d_first;
      req_b.b_first  = il_first;
      req_b.a_second = d_second;
      req_b.b_second = il_second;
    end else begin
      req_b.a_first  = ib_first;
      req_b.b_first  = ipw_first;
      req_b.a_second = ib_second;
      req_b.b_second = ipw_second;
    end
  end

  pph_modmul u_mul_a (.clk(clk), .rst(rst), .req(req_a), .rsp(rsp_a));
  pph_modmul u_mul_b (.clk(clk), .rst(rst), .req(req_b), .rsp(rsp_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      base_r    <= 21'd1000000;
      ib_first  <= 30'd1;
      ib_second <= 30'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        pph_pkg::REG_BASE:       base_r    <= cfg_data[20:0];
        pph_pkg::REG_INV_FIRST:  ib_first  <= cfg_data;
        pph_pkg::REG_INV_SECOND: ib_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      len         <= '0;
      pw_first    <= 30'd1;
      pw_second   <= 30'd1;
      ipw_first   <= 30'd1;
      ipw_second  <= 30'd1;
      last_first  <= '0;
      last_second <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            sym <= cmd.symbol;
            l_q <= cmd.range_start;
            if (cmd.command == pph_pkg::CMD_CLEAR) begin
              len         <= '0;
              pw_first    <= 30'd1;
              pw_second   <= 30'd1;
              ipw_first   <= 30'd1;
              ipw_second  <= 30'd1;
              last_first  <= '0;
              last_second <= '0;
            end else if (is_append) begin
              state <= S_AP1;
            end else if (is_query) begin
              if (q_bad) begin
                fin_first  <= '0;
                fin_second <= '0;
                fin_status <= 1'b1;
                state      <= S_FIN;
              end else begin
                state <= S_Q1;
              end
            end
          end
        end
        S_AP1: begin
          if (rsp_a.done) begin
            pw_first   <= rsp_a.p_first;
            pw_second  <= rsp_a.p_second;
            ipw_first  <= rsp_b.p_first;
            ipw_second <= rsp_b.p_second;
            state      <= S_AP2;
          end
        end
        S_AP2: begin
          if (rsp_a.done) begin
            last_first  <= sum_first;
            last_second <= sum_second;
            len         <= len + LW'(1);
            state       <= S_IDLE;
          end
        end
        S_Q1: begin
          hi_first  <= pre_rd[MW-1:pph_pkg::DW];
          hi_second <= pre_rd[pph_pkg::DW-1:0];
          il_first  <= inv_rd[MW-1:pph_pkg::DW];
          il_second <= inv_rd[pph_pkg::DW-1:0];
          state     <= S_Q2;
        end
        S_Q2: begin
          state <= S_Q3;
        end
        S_Q3: begin
          if (rsp_b.done) begin
            fin_first  <= rsp_b.p_first;
            fin_second <= rsp_b.p_second;
            fin_status <= 1'b0;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // finished result moves to the output register once it is free
  assign load_out = (state == S_FIN) && (!out_valid || res.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid  <= 1'b1;
      out_first  <= fin_first;
      out_second <= fin_second;
      out_status <= fin_status;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign res.valid       = out_valid;
  assign res.hash_first  = out_first;
  assign res.hash_second = out_second;
  assign res.status      = out_status;

endmodule

`default_nettype wire

@@ rtl/core/pph_checker.sv @@
// port-level checks on the result channel of the prefix hash core, with bind
// depends on pph_pkg and prefix_polynomial_hash_core_macros.svh
`default_nettype none

`include "prefix_polynomial_hash_core_macros.svh"

module pph_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           res_valid,
  input wire logic           res_ready,
  input wire pph_pkg::word_t hash_first,
  input wire pph_pkg::word_t hash_second,
  input wire logic           status
);

  // a stalled beat keeps its payload
  `PPH_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid && $stable(hash_first) && $stable(hash_second) && $stable(status), "result changed while stalled")

  // error results carry zero hashes
  `PPH_ASSERT_NOW(a_err_zero, res_valid && status, hash_first == '0 && hash_second == '0, "error result with nonzero hash")

  // hashes are fully reduced
  `PPH_ASSERT_NOW(a_reduced, res_valid, hash_first < pph_pkg::MOD_FIRST && hash_second < pph_pkg::MOD_SECOND, "hash not reduced")

endmodule

bind prefix_polynomial_hash_core pph_checker u_pph_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .hash_first  (res.hash_first),
  .hash_second (res.hash_second),
  .status      (res.status)
);

`default_nettype wire
